/* design/u8u2_pkg.sv */
package u8u2_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } u8u2_status_t;

  // one byte of the utf-8 stream
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } u8u2_in_t;

  // one decoded code unit
  typedef struct packed {
    logic [15:0]  code_unit;
    u8u2_status_t status;
    logic         end_of_text;
  } u8u2_out_t;

  // open sequence state
  typedef struct packed {
    logic [1:0]  pending;
    logic [15:0] partial;
  } u8u2_state_t;

  localparam logic [1:0] CONT_TAG = 2'b10;
  localparam logic [3:0] LEAD4_TAG = 4'hF;

endpackage

/* design/u8u2_step.sv */
module u8u2_step import u8u2_pkg::*; (
  input  u8u2_in_t    item,
  input  u8u2_state_t st,
  output logic        emit,
  output u8u2_out_t   res,
  output u8u2_state_t st_nxt
);

  logic        is_cont;
  logic [15:0] shifted;
  logic [1:0]  left;

  assign is_cont = (item.in_byte[7:6] == CONT_TAG);
  assign shifted = {st.partial[9:0], item.in_byte[5:0]};
  assign left    = st.pending - 2'd1;

  always_comb begin
    emit            = 1'b0;
    res.code_unit   = 16'h0000;
    res.status      = ST_OK;
    res.end_of_text = item.is_final;
    st_nxt.pending  = 2'd0;
    st_nxt.partial  = 16'h0000;
    if (st.pending != 2'd0) begin
      if (!is_cont) begin
        // broken sequence, byte dropped as well
        emit       = 1'b1;
        res.status = ST_INVALID;
      end else if (left == 2'd0) begin
        emit          = 1'b1;
        res.code_unit = shifted;
      end else if (item.is_final) begin
        emit       = 1'b1;
        res.status = ST_TRUNC;
      end else begin
        st_nxt.pending = left;
        st_nxt.partial = shifted;
      end
    end else if (!item.in_byte[7]) begin
      emit          = 1'b1;
      res.code_unit = {8'h00, item.in_byte};
    end else if (is_cont || (item.in_byte[7:4] == LEAD4_TAG)) begin
      // stray continuation or unsupported lead
      emit       = 1'b1;
      res.status = ST_INVALID;
    end else if (item.is_final) begin
      // lead byte that ends the text
      emit       = 1'b1;
      res.status = ST_TRUNC;
    end else if (!item.in_byte[5]) begin
      st_nxt.pending = 2'd1;
      st_nxt.partial = {11'h000, item.in_byte[4:0]};
    end else begin
      st_nxt.pending = 2'd2;
      st_nxt.partial = {12'h000, item.in_byte[3:0]};
    end
  end

endmodule

/* design/utf8_to_ucs2_decoder.sv */
// channel | ports                            | payload
// input   | in_valid, in_ready, in_data      | u8u2_in_t  (in_byte, is_final)
// result  | out_valid, out_ready, out_data   | u8u2_out_t (code_unit, status, end_of_text)
//
// one byte per cycle sustained unless a stalled result holds the decode stage; a
// byte reaches the result register by passing the input register and the decode step
// the decode step and the open-sequence state sit between the two registers
// synchronous active-low reset empties both registers and drops any open sequence
// a stalled result holds the decode stage only for a byte that makes a result;
// bytes that only extend a sequence keep flowing
module utf8_to_ucs2_decoder import u8u2_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  u8u2_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output u8u2_out_t out_data
);

  // input register
  logic        s1_valid_r;
  u8u2_in_t    s1_data_r;
  // open sequence state
  u8u2_state_t st_r;
  // result register
  logic        out_valid_r;
  u8u2_out_t   out_data_r;

  logic        step_emit;
  u8u2_out_t   step_res;
  u8u2_state_t st_nxt;
  logic        out_free;
  logic        s1_move;

  u8u2_step u_step (
    .item   (s1_data_r),
    .st     (st_r),
    .emit   (step_emit),
    .res    (step_res),
    .st_nxt (st_nxt)
  );

  // result slot frees when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ready;
  // decode stage retires its byte unless it has a result with nowhere to go
  assign s1_move  = s1_valid_r && (!step_emit || out_free);
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      // input register
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      // state only changes when a byte is retired
      if (s1_move) begin
        st_r <= st_nxt;
      end
      // result register
      if (s1_move && step_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_move && step_emit) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // error results never carry a code unit
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.code_unit == 16'h0000))
    else $error("error result with nonzero code unit");

  // at most two continuations are ever expected
  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pending != 2'd3)
    else $error("pending count out of range");

  // a final byte always leaves no open sequence and makes a result
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_data_r.is_final) |=> (st_r.pending == 2'd0) && out_valid_r
      && out_data_r.end_of_text)
    else $error("final byte left sequence open or gave no result");

  // a result waiting on a stall is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_move && step_emit))
    else $error("result register overwritten while stalled");

endmodule
